>>> hdl/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

  // Operand width that the datapath keeps; wider selections are cut to it.
  localparam int VALUE_WIDTH = 64;

  // Character slots: the octal form is the longest form of any operand.
  localparam int NUM_SLOTS = (VALUE_WIDTH + 2) / 3;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int DIG_W     = 4 * NUM_SLOTS;
  localparam int OCT_W     = 3 * NUM_SLOTS;

  // Binary to BCD conversion takes CONV_STEP operand bits per cycle.
  localparam int CONV_STEP   = 8;
  localparam int CONV_CYCLES = (VALUE_WIDTH + CONV_STEP - 1) / CONV_STEP;
  localparam int CONV_W      = CONV_CYCLES * CONV_STEP;
  localparam int CONV_CNT_W  = $clog2(CONV_CYCLES + 1);

  // Work queue between the front and back ends.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Width selector codes; the remaining codes select 64 bits.
  localparam logic [2:0] WSEL_INT   = 3'd0;
  localparam logic [2:0] WSEL_CHAR  = 3'd1;
  localparam logic [2:0] WSEL_SHORT = 3'd2;
  localparam logic [2:0] WSEL_LONG  = 3'd3;
  localparam logic [2:0] WSEL_LLONG = 3'd4;

  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [3:0] DEC_BASE     = 4'd10;

  typedef enum logic [1:0] {
    RADIX_DEC  = 2'd0,
    RADIX_OCT  = 2'd1,
    RADIX_HEX  = 2'd2,
    RADIX_NONE = 2'd3
  } radix_t;

  // One classified item: magnitude already masked, and negated if negative.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    radix_t                 radix;
    logic                   upper;
  } work_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < DEC_BASE) begin
      digit_char = CHAR_ZERO + {4'd0, d};
    end else begin
      base       = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      digit_char = base + {4'd0, d} - {4'd0, DEC_BASE};
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/i2a_in_if.sv
`default_nettype none

interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [2:0]  width_sel;
  logic        is_signed;
  logic [1:0]  cmd;
  logic        upper_case;

  modport source (output valid, value, width_sel, is_signed, cmd, upper_case, input ready);
  modport sink   (input valid, value, width_sel, is_signed, cmd, upper_case, output ready);
endinterface

`default_nettype wire

>>> hdl/i2a_out_if.sv
`default_nettype none

interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_char;

  modport source (output valid, text_byte, last_char, input ready);
  modport sink   (input valid, text_byte, last_char, output ready);
endinterface

`default_nettype wire

>>> hdl/i2a_front.sv
`default_nettype none

module i2a_front import i2a_pkg::*; (
  i2a_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    q_push,
  output work_t   q_data
);

  logic [6:0]             sel_w;
  logic [6:0]             eff_w;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mask;
  logic [VALUE_WIDTH-1:0] masked;
  logic [VALUE_WIDTH-1:0] top_bit;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   sign_bit;
  logic                   neg;
  radix_t                 rad;

  always_comb begin
    case (in_ch.width_sel)
      WSEL_INT:   sel_w = 7'd32;
      WSEL_CHAR:  sel_w = 7'd8;
      WSEL_SHORT: sel_w = 7'd16;
      default:    sel_w = 7'd64;
    endcase
    eff_w = (sel_w > 7'(VALUE_WIDTH)) ? 7'(VALUE_WIDTH) : sel_w;

    raw = in_ch.value[VALUE_WIDTH-1:0];
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      mask[i] = (7'(i) < eff_w);
    end
    masked  = raw & mask;
    // The sign sits at the highest bit that the mask keeps.
    top_bit  = mask & ~(mask >> 1);
    sign_bit = |(masked & top_bit);

    rad = radix_t'(in_ch.cmd);
    neg = (rad == RADIX_DEC) && in_ch.is_signed && sign_bit;
    mag = neg ? ((~masked + VALUE_WIDTH'(1)) & mask) : masked;

    in_ch.ready = !q_full;
    q_push      = in_ch.valid && !q_full && (rad != RADIX_NONE);
    q_data      = '{mag: mag, neg: neg, radix: rad, upper: in_ch.upper_case};
  end

endmodule

`default_nettype wire

>>> hdl/i2a_queue.sv
`default_nettype none

module i2a_queue import i2a_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t din,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output work_t dout
);

  work_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_r;
  logic [QPTR_W-1:0]  rd_r;
  logic [QCNT_W-1:0]  cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (pop) begin
        rd_r <= ptr_inc(rd_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue popped while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + QCNT_W'(1))
    else $error("queue push lost");

endmodule

`default_nettype wire

>>> hdl/i2a_back.sv
`default_nettype none

module i2a_back import i2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  work_t      q_entry,
  output logic       q_pop,
  i2a_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_FIND,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                state_r,     state_nxt;
  logic [DIG_W-1:0]      dig_r,       dig_nxt;
  logic [CONV_W-1:0]     conv_r,      conv_nxt;
  logic [CONV_CNT_W-1:0] cnt_r,       cnt_nxt;
  logic [SLOT_W-1:0]     idx_r,       idx_nxt;
  logic                  neg_r,       neg_nxt;
  logic                  upper_r,     upper_nxt;
  radix_t                rad_r,       rad_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            text_r,      text_nxt;
  logic                  last_r,      last_nxt;

  logic [DIG_W-1:0]  dab_dig;
  logic [CONV_W-1:0] dab_conv;
  logic [DIG_W-1:0]  oct_dig;
  logic [OCT_W-1:0]  oct_src;
  logic [SLOT_W-1:0] top_idx;
  logic [3:0]        cur_dig;
  logic              slot_free;
  logic              bcd_ok;

  // Shift-and-add-3 conversion, CONV_STEP operand bits per cycle.
  always_comb begin
    dab_dig  = dig_r;
    dab_conv = conv_r;
    for (int b = 0; b < CONV_STEP; b++) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (dab_dig[4*j +: 4] >= 4'd5) begin
          dab_dig[4*j +: 4] = dab_dig[4*j +: 4] + 4'd3;
        end
      end
      dab_dig  = {dab_dig[DIG_W-2:0], dab_conv[CONV_W-1]};
      dab_conv = {dab_conv[CONV_W-2:0], 1'b0};
    end
  end

  always_comb begin
    oct_src = OCT_W'(q_entry.mag);
    for (int j = 0; j < NUM_SLOTS; j++) begin
      oct_dig[4*j +: 4] = {1'b0, oct_src[3*j +: 3]};
    end
  end

  // Highest nonzero character slot; zero gives slot 0 and a lone '0'.
  always_comb begin
    top_idx = '0;
    bcd_ok  = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (dig_r[4*i +: 4] != 4'd0) begin
        top_idx = SLOT_W'(i);
      end
      if (dig_r[4*i +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  assign cur_dig   = dig_r[{idx_r, 2'b00} +: 4];
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    conv_nxt      = conv_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    rad_nxt       = rad_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    text_nxt      = text_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          neg_nxt   = q_entry.neg;
          upper_nxt = q_entry.upper;
          rad_nxt   = q_entry.radix;
          if (q_entry.radix == RADIX_DEC) begin
            dig_nxt   = '0;
            conv_nxt  = CONV_W'(q_entry.mag);
            cnt_nxt   = CONV_CNT_W'(CONV_CYCLES);
            state_nxt = S_CONV;
          end else if (q_entry.radix == RADIX_HEX) begin
            dig_nxt   = DIG_W'(q_entry.mag);
            state_nxt = S_FIND;
          end else begin
            dig_nxt   = oct_dig;
            state_nxt = S_FIND;
          end
        end
      end
      S_CONV: begin
        dig_nxt  = dab_dig;
        conv_nxt = dab_conv;
        cnt_nxt  = cnt_r - CONV_CNT_W'(1);
        if (cnt_r == CONV_CNT_W'(1)) begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        idx_nxt   = top_idx;
        state_nxt = neg_r ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          text_nxt      = CHAR_MINUS;
          last_nxt      = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          text_nxt      = digit_char(cur_dig, upper_r);
          last_nxt      = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - SLOT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dig_r   <= dig_nxt;
    conv_r  <= conv_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    neg_r   <= neg_nxt;
    upper_r <= upper_nxt;
    rad_r   <= rad_nxt;
    text_r  <= text_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_byte = text_r;
  assign out_ch.last_char = last_r;

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND && rad_r == RADIX_DEC) |-> bcd_ok)
    else $error("decimal conversion left a digit above nine");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> idx_r <= SLOT_W'(NUM_SLOTS - 1))
    else $error("character index beyond the slot range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && text_r == CHAR_MINUS) |-> !last_r)
    else $error("minus sign marked as final character");

  a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_CONV || state_r == S_FIND))
    else $error("popped item did not start work");

endmodule

`default_nettype wire

>>> hdl/integer_to_ascii_radix_core.sv
`default_nettype none

// Binary to ASCII text in decimal, octal or hexadecimal. Each accepted item
// (operand, width selector, signedness, radix command, letter case) yields
// one output transfer per character, most significant first, with
// last_char set on the final one; signed decimal negatives are preceded by
// '-', zero gives a single '0', and a radix command of 3 is accepted but
// gives no characters. The front end masks and negates the operand in the
// accept cycle and writes it into a two-entry queue, so input transfers
// continue while the back end is still busy with earlier items. The back
// end takes one item at a time: it loads the item, then for decimal runs
// the binary to BCD conversion at 8 bits per cycle, finds the leading
// digit, and then sends the '-', if any, and the characters through the
// output register, where the output side can stall it. An item gives at
// most 22 characters.
module integer_to_ascii_radix_core import i2a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  i2a_in_if.sink    in_ch,
  i2a_out_if.source out_ch
);

  // Classified work travels from the front end to the back end here.
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  work_t q_din;
  work_t q_dout;

  // Front end: width masking, sign handling and radix decode.
  i2a_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_din)
  );

  // Short queue that lets the input side run ahead of character output.
  i2a_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  // Back end: digit generation and the registered character output.
  i2a_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_dout),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
